/* hw/rtl/dklb_pkg.sv */
package dklb_pkg;

    localparam int MaxKeys    = 16;
    localparam int IdxW       = 4;
    localparam int SlotW      = 5;
    localparam int CountW     = 5;
    localparam int FracBits   = 16;
    localparam int TimeW      = 21;
    localparam int ValueW     = 32;
    localparam int ProgW      = 17;
    localparam int DayTicks   = 24 << FracBits;
    // Times plus one day fit in 22 bits; keep a sign bit for differences.
    localparam int WideTimeW  = 24;
    localparam int QuotW      = FracBits + 1;

    localparam logic [1:0] CFG_COUNT_A = 2'd0;
    localparam logic [1:0] CFG_COUNT_B = 2'd1;
    localparam logic [1:0] CFG_DEFAULT = 2'd2;
    localparam logic [1:0] CFG_BLEND   = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic             table_select;
        logic [IdxW-1:0]  key_index;
        logic [TimeW-1:0] key_time;
        logic signed [ValueW-1:0] key_value;
        logic [TimeW-1:0] eval_time;
        logic [ProgW-1:0] blend_progress;
    } item_t;

    typedef struct packed {
        logic signed [ValueW-1:0] result_value;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WAIT_S,
        ST_READ_E,
        ST_WAIT_E,
        ST_DIVIDE,
        ST_LERP,
        ST_BLEND,
        ST_MUL,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/dklb_if.sv */
interface dklb_in_if;
    import dklb_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dklb_out_if;
    import dklb_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/daily_keyframe_lerp_blend_unit.sv */
// A load is written to keyframe memory when accepted, and the next item may follow
// at once unless a result is waiting. An evaluation with table A empty returns the
// default. Each table takes a backward scan, a wrap read when no key lies at or
// before the time, the end read, a divide unless the segment is flat or finished,
// a multiply and an add. Blending adds table B when it holds keys and a crossfade
// pass; the next item is taken the cycle after the result is. Reset clears
// the configuration and the controller; keyframe memory is undefined until loaded.
module daily_keyframe_lerp_blend_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [dklb_pkg::ValueW-1:0]        cfg_data,
    dklb_in_if.sink                            in_ch,
    dklb_out_if.source                         out_ch
);
    import dklb_pkg::*;

    state_t state_reg, state_next;

    logic [CountW-1:0]  count_a_reg, count_b_reg;
    logic [ValueW-1:0]  default_reg;
    logic               blend_reg;

    logic               tab_reg, tab_next;
    logic               xf_reg, xf_next;     // crossfade pass through the multiplier
    logic [CountW-1:0]  n_reg, n_next;
    logic [IdxW:0]      i_reg, i_next;      // scan position, counts down
    logic [IdxW-1:0]    s_reg, s_next;
    logic               pend_reg, pend_next; // a read is in flight
    logic [TimeW-1:0]   st_reg, st_next;
    logic [ValueW-1:0]  sv_reg, sv_next;
    logic [WideTimeW-1:0] tw_reg, tw_next;
    logic [ValueW-1:0]  va_reg, va_next;
    logic [TimeW-1:0]   et_reg;
    logic [ProgW-1:0]   prog_reg;
    logic [ValueW-1:0]  lo_reg, hi_reg;
    logic               up_reg;
    logic [QuotW-1:0]   frac_reg;
    logic [ValueW+QuotW-1:0] prod_reg;
    logic               out_valid_reg;
    logic [ValueW-1:0]  out_reg;

    logic [SlotW-1:0]   rd_addr;
    logic [TimeW-1:0]   rd_time;
    logic [ValueW-1:0]  rd_value;
    logic               mem_we;
    logic [SlotW-1:0]   wr_addr;

    logic               div_start, div_busy;
    logic [WideTimeW-1:0] div_num, div_den;
    logic [QuotW-1:0]   div_q;

    logic               accept;
    logic               ev_ready;

    assign accept  = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign mem_we  = accept && (in_ch.data.opcode == OP_LOAD);
    assign wr_addr = {in_ch.data.table_select, in_ch.data.key_index};

    dklb_keymem u_mem (
        .clk      (clk),
        .wr_en    (mem_we),
        .wr_addr  (wr_addr),
        .wr_time  (in_ch.data.key_time),
        .wr_value (in_ch.data.key_value),
        .rd_addr  (rd_addr),
        .rd_time  (rd_time),
        .rd_value (rd_value)
    );

    dklb_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg <= '0;
            count_b_reg <= '0;
            default_reg <= '0;
            blend_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COUNT_A: count_a_reg <= cfg_data[CountW-1:0];
                CFG_COUNT_B: count_b_reg <= cfg_data[CountW-1:0];
                CFG_DEFAULT: default_reg <= cfg_data;
                CFG_BLEND:   blend_reg   <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // Datapath quantities for the current segment.
    logic [WideTimeW-1:0] sf_w, ef_w, span_w, dt_w;
    logic [IdxW:0]        e_idx;
    logic                 e_wraps;
    logic                 sv_ge_ev;
    logic                 seg_flat, seg_full;
    logic [CountW-1:0]    cap_a, cap_b;

    always_comb
    begin
        cap_a = (count_a_reg > CountW'(MaxKeys)) ? CountW'(MaxKeys) : count_a_reg;
        cap_b = (count_b_reg > CountW'(MaxKeys)) ? CountW'(MaxKeys) : count_b_reg;
        e_idx = ({1'b0, s_reg} + 1'b1 == n_reg) ? '0 : {1'b0, s_reg} + 1'b1;
        e_wraps = (e_idx[IdxW-1:0] <= s_reg);
        sf_w = WideTimeW'(st_reg);
        ef_w = WideTimeW'(rd_time) + (e_wraps ? WideTimeW'(DayTicks) : '0);
        span_w = ef_w - sf_w;
        dt_w = tw_reg - sf_w;
        sv_ge_ev = ($signed(rd_value) >= $signed(sv_reg));
        // A flat segment keeps the start value; past its end the fraction is one.
        seg_flat = span_w[WideTimeW-1] || (span_w == '0) || dt_w[WideTimeW-1] || (dt_w == '0);
        seg_full = !seg_flat && (dt_w >= span_w);
    end

    assign div_num = dt_w;
    assign div_den = span_w;

    logic [ValueW-1:0] off;
    assign off = prod_reg[ValueW+FracBits-1:FracBits];

    logic [QuotW-1:0] prog_sat;
    assign prog_sat = (prog_reg > ProgW'(1 << FracBits))
                      ? QuotW'(1 << FracBits) : prog_reg[QuotW-1:0];

    logic [ValueW-1:0] lerp_res;
    assign lerp_res = up_reg ? lo_reg + off : lo_reg - off;

    // The crossfade runs from A toward B, or toward the default when B is empty.
    logic [ValueW-1:0] xf_tgt;
    logic              xf_up;
    assign xf_tgt = (state_reg == ST_BLEND) ? default_reg : lerp_res;
    assign xf_up  = ($signed(xf_tgt) >= $signed(va_reg));

    always_comb
    begin
        state_next = state_reg;
        tab_next   = tab_reg;
        xf_next    = xf_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        s_next     = s_reg;
        pend_next  = 1'b0;
        st_next    = st_reg;
        sv_next    = sv_reg;
        tw_next    = tw_reg;
        va_next    = va_reg;
        rd_addr    = {tab_reg, s_reg};
        div_start  = 1'b0;
        ev_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_ch.data.opcode == OP_EVAL)
                begin
                    tab_next = 1'b0;
                    xf_next  = 1'b0;
                    if (count_a_reg == '0)
                    begin
                        va_next = default_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        n_next = cap_a;
                        i_next = cap_a;
                        tw_next = WideTimeW'(in_ch.data.eval_time);
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // Issue read of entry i-1; previous read compared here.
                if (pend_reg && (WideTimeW'(rd_time) <= tw_reg))
                begin
                    st_next = rd_time;
                    sv_next = rd_value;
                    state_next = ST_READ_E;
                end
                else if (i_reg == '0)
                begin
                    // Nothing at or before t: wrap from the last keyframe.
                    s_next = n_reg[IdxW-1:0] - 1'b1;
                    tw_next = tw_reg + WideTimeW'(DayTicks);
                    rd_addr = {tab_reg, n_reg[IdxW-1:0] - 1'b1};
                    state_next = ST_WAIT_S;
                end
                else
                begin
                    s_next = i_reg[IdxW-1:0] - 1'b1;
                    i_next = i_reg - 1'b1;
                    rd_addr = {tab_reg, i_reg[IdxW-1:0] - 1'b1};
                    pend_next = 1'b1;
                end
            end
            ST_WAIT_S:
            begin
                st_next = rd_time;
                sv_next = rd_value;
                state_next = ST_READ_E;
            end
            ST_READ_E:
            begin
                rd_addr = {tab_reg, e_idx[IdxW-1:0]};
                state_next = ST_WAIT_E;
            end
            ST_WAIT_E:
            begin
                if (seg_flat || seg_full)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    div_start = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (!div_busy)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_LERP;
            end
            ST_LERP:
            begin
                if (xf_reg)
                begin
                    va_next = lerp_res;
                    state_next = ST_DONE;
                end
                else if (!tab_reg)
                begin
                    va_next = lerp_res;
                    state_next = ST_BLEND;
                end
                else
                begin
                    xf_next = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_BLEND:
            begin
                // Arrived with table A's value in va_reg.
                if (!blend_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (count_b_reg == '0)
                begin
                    xf_next = 1'b1;
                    state_next = ST_MUL;
                end
                else
                begin
                    tab_next = 1'b1;
                    n_next = cap_b;
                    i_next = cap_b;
                    tw_next = WideTimeW'(et_reg);
                    state_next = ST_SEARCH;
                end
            end
            ST_DONE:
            begin
                ev_ready = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Operand capture for the shared multiplier.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    et_reg   <= in_ch.data.eval_time;
                    prog_reg <= in_ch.data.blend_progress;
                end
            end
            ST_WAIT_E:
            begin
                lo_reg   <= sv_reg;
                up_reg   <= sv_ge_ev;
                hi_reg   <= sv_ge_ev ? rd_value - sv_reg : sv_reg - rd_value;
                frac_reg <= seg_full ? QuotW'(1 << FracBits) : '0;
            end
            ST_DIVIDE:
            begin
                if (!div_busy)
                begin
                    frac_reg <= div_q;
                end
            end
            ST_BLEND, ST_LERP:
            begin
                if (state_reg == ST_BLEND || (tab_reg && !xf_reg))
                begin
                    lo_reg   <= va_reg;
                    up_reg   <= xf_up;
                    hi_reg   <= xf_up ? xf_tgt - va_reg : va_reg - xf_tgt;
                    frac_reg <= prog_sat;
                end
            end
            ST_MUL:
            begin
                prod_reg <= hi_reg * frac_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tab_reg       <= 1'b0;
            xf_reg        <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tab_reg   <= tab_next;
            xf_reg    <= xf_next;
            pend_reg  <= pend_next;
            if (ev_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        s_reg     <= s_next;
        st_reg    <= st_next;
        sv_reg    <= sv_next;
        tw_reg    <= tw_next;
        va_reg    <= va_next;
        if (ev_ready)
        begin
            out_reg <= va_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data.result_value = out_reg;

    property p_ready_idle;
        @(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (state_reg == ST_IDLE);
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

    property p_one_result;
        @(posedge clk) disable iff (!rst_n)
        ev_ready |-> !out_valid_reg;
    endproperty
    a_one_result: assert property (p_one_result) else $error("result overwritten");

    property p_div_wait;
        @(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy;
    endproperty
    a_div_wait: assert property (p_div_wait) else $error("divider did not start");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_reg);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped while waiting");

endmodule

/* hw/rtl/dklb_keymem.sv */
module dklb_keymem (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [dklb_pkg::SlotW-1:0]     wr_addr,
    input  logic [dklb_pkg::TimeW-1:0]     wr_time,
    input  logic [dklb_pkg::ValueW-1:0]    wr_value,
    input  logic [dklb_pkg::SlotW-1:0]     rd_addr,
    output logic [dklb_pkg::TimeW-1:0]     rd_time,
    output logic [dklb_pkg::ValueW-1:0]    rd_value
);
    import dklb_pkg::*;

    logic [TimeW+ValueW-1:0] mem [0:2*MaxKeys-1];
    logic [TimeW+ValueW-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_time, wr_value};
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_time  = rd_reg[TimeW+ValueW-1:ValueW];
    assign rd_value = rd_reg[ValueW-1:0];
endmodule

/* hw/rtl/dklb_divider.sv */
module dklb_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [dklb_pkg::WideTimeW-1:0]     dividend,
    input  logic [dklb_pkg::WideTimeW-1:0]     divisor,
    output logic                               busy,
    output logic [dklb_pkg::QuotW-1:0]         quotient
);
    import dklb_pkg::*;

    // Restoring division of dividend * 2^FracBits by divisor, one quotient
    // bit per cycle. The caller guarantees dividend < divisor, so the
    // quotient fits in FracBits bits.
    localparam int CntW = $clog2(QuotW + 1);

    logic [WideTimeW:0]   rem_reg,  rem_next;
    logic [WideTimeW-1:0] den_reg;
    logic [QuotW-1:0]     q_reg,    q_next;
    logic [CntW-1:0]      cnt_reg;
    logic [WideTimeW:0]   trial;

    always_comb
    begin
        trial    = {rem_reg[WideTimeW-1:0], 1'b0} - {1'b0, den_reg};
        rem_next = {rem_reg[WideTimeW-1:0], 1'b0};
        q_next   = {q_reg[QuotW-2:0], 1'b0};
        if (!trial[WideTimeW])
        begin
            rem_next = trial;
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CntW'(FracBits);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend};
            den_reg <= divisor;
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;
endmodule

/* tb/tb_daily_keyframe_lerp_blend_unit.sv */
`timescale 1ns / 100ps

module tb_daily_keyframe_lerp_blend_unit;
    import dklb_pkg::*;

    localparam int HOUR = 1 << FracBits;
    localparam int TIME_MAX = DayTicks - 1;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        bit                       is_cfg;
        logic [1:0]               cfg_idx;
        logic [ValueW-1:0]        cfg_val;
        item_t                    it;
        bit                       has_lit;
        logic signed [ValueW-1:0] lit_val;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [ValueW-1:0] cfg_data = '0;

    dklb_in_if  in_ch();
    dklb_out_if out_ch();

    daily_keyframe_lerp_blend_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow copy of the block's configuration and keyframe memory.
    logic [CountW-1:0]        cnt_a, cnt_b;
    logic signed [ValueW-1:0] dflt_val;
    logic                     blend_on;
    logic [TimeW-1:0]         key_t_mem [2*MaxKeys];
    logic signed [ValueW-1:0] key_v_mem [2*MaxKeys];

    logic signed [ValueW-1:0] blend_values_q[$];
    row_t rows[$];

    int  idle_pct = 0;
    int  stall_pct = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  lit_on = 1'b0;
    logic signed [ValueW-1:0] lit_val = '0;

    always #2 clk = ~clk;

    // Start value plus the offset toward the end value, truncated toward the start.
    function automatic logic signed [ValueW-1:0] lerp_q(input logic signed [ValueW-1:0] a,
                                                        input logic signed [ValueW-1:0] b,
                                                        input longint frac);
        longint la, lb, off;
        la = a;
        lb = b;
        if (lb >= la)
        begin
            off = ((lb - la) * frac) >>> FracBits;
            return ValueW'(la + off);
        end
        off = ((la - lb) * frac) >>> FracBits;
        return ValueW'(la - off);
    endfunction

    function automatic logic signed [ValueW-1:0] table_at(input bit tab,
                                                          input logic [TimeW-1:0] tr);
        int n, base, s, e, found;
        longint t, sf, ef, span, dt, frac;
        logic signed [ValueW-1:0] sv, ev;
        n = tab ? int'(cnt_b) : int'(cnt_a);
        if (n > MaxKeys)
            n = MaxKeys;
        if (n == 0)
            return dflt_val;
        base = tab ? MaxKeys : 0;
        t = tr;
        found = -1;
        for (int i = n - 1; i >= 0; i--)
        begin
            if (t >= longint'(key_t_mem[base + i]))
            begin
                found = i;
                break;
            end
        end
        if (found >= 0)
        begin
            s = found;
            e = (s + 1) % n;
        end
        else
        begin
            s = n - 1;
            e = 0;
            t += DayTicks;
        end
        sf = key_t_mem[base + s];
        ef = key_t_mem[base + e];
        if (e <= s)
            ef += DayTicks;
        sv = key_v_mem[base + s];
        ev = key_v_mem[base + e];
        if (sv == ev)
            return sv;
        span = ef - sf;
        if (span <= 0)
            return sv;
        dt = t - sf;
        if (dt <= 0)
            frac = 0;
        else
        begin
            frac = (dt << FracBits) / span;
            if (frac > HOUR)
                frac = HOUR;
        end
        return lerp_q(sv, ev, frac);
    endfunction

    function automatic logic signed [ValueW-1:0] blended_value(input item_t it);
        logic signed [ValueW-1:0] a, b;
        longint p;
        if (cnt_a == 0)
            return dflt_val;
        a = table_at(1'b0, it.eval_time);
        if (blend_on)
        begin
            b = table_at(1'b1, it.eval_time);
            if (a != b)
            begin
                p = it.blend_progress;
                if (p > HOUR)
                    p = HOUR;
                a = lerp_q(a, b, p);
            end
        end
        return a;
    endfunction

    always @(negedge clk)
        out_ch.ready = ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Accepted inputs update the shadow state or queue an expected value;
    // accepted outputs are checked against the oldest expectation.
    always @(posedge clk)
    begin
        logic signed [ValueW-1:0] want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            if (in_ch.data.opcode == OP_LOAD)
            begin
                key_t_mem[{in_ch.data.table_select, in_ch.data.key_index}] = in_ch.data.key_time;
                key_v_mem[{in_ch.data.table_select, in_ch.data.key_index}] = in_ch.data.key_value;
            end
            else
                blend_values_q.push_back(lit_on ? lit_val : blended_value(in_ch.data));
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (blend_values_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result_value %h", out_ch.data.result_value);
            end
            else
            begin
                want = blend_values_q.pop_front();
                if (out_ch.data.result_value !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result_value mismatch: expected %h, got %h",
                                 want, out_ch.data.result_value);
                end
            end
        end
    end

    // Once an item is offered, valid stays high until the item is accepted.
    task automatic send_item(input item_t it, input bit has_lit,
                             input logic signed [ValueW-1:0] lv);
        bit shown;
        shown = 1'b0;
        do
        begin
            @(negedge clk);
            lit_on = has_lit;
            lit_val = lv;
            if (!shown && $urandom_range(99) < idle_pct)
                in_ch.valid = 1'b0;
            else
            begin
                in_ch.valid = 1'b1;
                in_ch.data = it;
                shown = 1'b1;
            end
            @(posedge clk);
        end
        while (!(in_ch.valid && in_ch.ready));
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (blend_values_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [ValueW-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            CFG_COUNT_A: cnt_a = val[CountW-1:0];
            CFG_COUNT_B: cnt_b = val[CountW-1:0];
            CFG_DEFAULT: dflt_val = val;
            CFG_BLEND:   blend_on = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic item_t load_item(input bit tab, input int idx, input int t, input int v);
        item_t it;
        it = '0;
        it.opcode = OP_LOAD;
        it.table_select = tab;
        it.key_index = idx[IdxW-1:0];
        it.key_time = t[TimeW-1:0];
        it.key_value = v;
        return it;
    endfunction

    function automatic item_t eval_item(input int t, input int prog);
        item_t it;
        it = '0;
        it.opcode = OP_EVAL;
        it.eval_time = t[TimeW-1:0];
        it.blend_progress = prog[ProgW-1:0];
        return it;
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [ValueW-1:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        rows.push_back(r);
    endfunction

    function automatic void add_item(input item_t it, input bit has_lit,
                                     input logic signed [ValueW-1:0] lv);
        row_t r;
        r = '{default: '0};
        r.it = it;
        r.has_lit = has_lit;
        r.lit_val = lv;
        rows.push_back(r);
    endfunction

    function automatic item_t random_item();
        item_t it;
        int sel;
        it.opcode = OP_EVAL;
        it.table_select = 1'($urandom_range(1));
        it.key_index = IdxW'($urandom_range(MaxKeys - 1));
        it.key_time = TimeW'($urandom_range(TIME_MAX));
        it.key_value = $urandom;
        it.eval_time = TimeW'($urandom_range(TIME_MAX));
        it.blend_progress = ProgW'($urandom_range((1 << ProgW) - 1));
        if ($urandom_range(3) == 0)
            it.opcode = OP_LOAD;
        sel = $urandom_range(15);
        if (sel == 0)
            it.eval_time = '0;
        else if (sel == 1)
            it.eval_time = TimeW'(TIME_MAX);
        else if (sel == 2)
            it.eval_time = key_t_mem[$urandom_range(2 * MaxKeys - 1)];
        sel = $urandom_range(15);
        if (sel == 0)
            it.blend_progress = '0;
        else if (sel == 1)
            it.blend_progress = ProgW'(HOUR);
        else if (sel == 2)
            it.blend_progress = ProgW'((1 << ProgW) - 1);
        return it;
    endfunction

    function automatic int pick_count();
        case ($urandom_range(5))
            0: return 0;
            1: return 1;
            2: return MaxKeys;
            3: return 31;
            default: return $urandom_range(2, MaxKeys);
        endcase
    endfunction

    // Refill one table with ascending key times and random values.
    task automatic reload_sorted(input bit tab, input int n);
        int t;
        t = $urandom_range(3 * HOUR);
        for (int i = 0; i < n; i++)
        begin
            send_item(load_item(tab, i, t, $urandom), 1'b0, '0);
            t += $urandom_range(1, (TIME_MAX - t) / (n - i + 1) + 1);
            if (t > TIME_MAX)
                t = TIME_MAX;
        end
    endtask

    initial
    begin
        int c;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cnt_a = '0;
        cnt_b = '0;
        dflt_val = '0;
        blend_on = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part.
        add_item(eval_item(0, 0), 1'b1, 32'sh0);
        add_cfg(CFG_DEFAULT, 32'h8000_0000);
        add_item(eval_item(TIME_MAX, (1 << ProgW) - 1), 1'b1, 32'sh8000_0000);
        add_cfg(CFG_BLEND, 32'd1);
        add_item(eval_item(5 * HOUR, HOUR), 1'b1, 32'sh8000_0000);
        add_cfg(CFG_DEFAULT, 32'h7FFF_FFFF);
        add_item(eval_item(0, 0), 1'b1, 32'sh7FFF_FFFF);
        add_item(load_item(1'b0, 0, 0, 32'h8000_0000), 1'b0, '0);
        add_item(load_item(1'b0, 1, 12 * HOUR, 32'h7FFF_FFFF), 1'b0, '0);
        add_cfg(CFG_COUNT_A, 32'd2);
        add_cfg(CFG_BLEND, 32'd0);
        add_item(eval_item(0, 0), 1'b1, 32'sh8000_0000);
        add_item(eval_item(12 * HOUR, 0), 1'b1, 32'sh7FFF_FFFF);
        add_item(eval_item(6 * HOUR, 0), 1'b0, '0);
        add_item(eval_item(18 * HOUR, 0), 1'b0, '0);
        add_item(eval_item(TIME_MAX, 0), 1'b0, '0);
        add_item(load_item(1'b0, 0, 2 * HOUR, 32'h8000_0000), 1'b0, '0);
        add_item(eval_item(HOUR, 0), 1'b0, '0);
        add_item(load_item(1'b0, 1, 12 * HOUR, 32'h8000_0000), 1'b0, '0);
        add_item(eval_item(7 * HOUR, 0), 1'b1, 32'sh8000_0000);
        add_cfg(CFG_COUNT_B, 32'd16);
        add_cfg(CFG_BLEND, 32'd1);
        add_item(eval_item(5 * HOUR, 0), 1'b0, '0);
        add_item(eval_item(5 * HOUR, HOUR), 1'b0, '0);
        add_item(eval_item(5 * HOUR, (1 << ProgW) - 1), 1'b0, '0);
        add_item(eval_item(5 * HOUR, 12345), 1'b0, '0);
        add_cfg(CFG_COUNT_A, 32'd31);
        add_item(eval_item(20 * HOUR, 40000), 1'b0, '0);
        add_cfg(CFG_COUNT_B, 32'd1);
        add_item(eval_item(3 * HOUR, HOUR / 2), 1'b0, '0);

        // Every slot gets written before any count exposes it.
        for (int s = 0; s < 2 * MaxKeys; s++)
            send_item(load_item(1'(s / MaxKeys), s % MaxKeys, (s % MaxKeys) * (3 * HOUR / 2),
                                $urandom), 1'b0, '0);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                drain();
                write_cfg(rows[i].cfg_idx, rows[i].cfg_val);
            end
            else
                send_item(rows[i].it, rows[i].has_lit, rows[i].lit_val);
        end

        // Random part: four idling phases, each with three settings.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            for (int k = 0; k < 3; k++)
            begin
                drain();
                c = pick_count();
                write_cfg(CFG_COUNT_A, 32'(c));
                write_cfg(CFG_COUNT_B, 32'(pick_count()));
                write_cfg(CFG_BLEND, 32'($urandom_range(3) != 0));
                case ($urandom_range(3))
                    0: write_cfg(CFG_DEFAULT, 32'h8000_0000);
                    1: write_cfg(CFG_DEFAULT, 32'h7FFF_FFFF);
                    default: write_cfg(CFG_DEFAULT, $urandom);
                endcase
                reload_sorted(1'b0, (c > MaxKeys || c == 0) ? MaxKeys : c);
                reload_sorted(1'b1, $urandom_range(1, MaxKeys));
                for (int j = 0; j < 52; j++)
                    send_item(random_item(), 1'b0, '0);
            end
        end

        drain();
        if (mismatches == 0 && blend_values_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/dklb_pkg.sv
hw/rtl/dklb_if.sv
hw/rtl/dklb_keymem.sv
hw/rtl/dklb_divider.sv
hw/rtl/daily_keyframe_lerp_blend_unit.sv
tb/tb_daily_keyframe_lerp_blend_unit.sv
